// ===== sv/tlb_address_translator_unit_defines.svh =====
// Assertion macros used by the address translator checker.
`ifndef TLB_ADDRESS_TRANSLATOR_UNIT_DEFINES_SVH
`define TLB_ADDRESS_TRANSLATOR_UNIT_DEFINES_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define TLBAT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("tlbat assertion failed");

// Checks that a condition in one cycle implies a condition in the next cycle.
`define TLBAT_ASSERT_NEXT(lbl, cond, nxt) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error("tlbat assertion failed");

`endif

// ===== sv/tlbat_pkg.sv =====
// Package with the types, codes and helper functions of the address translator.
`timescale 1ns / 1ps
package tlbat_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = ADDR_W + 1;
	localparam int ENTRY_W = 52;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_FLUSH = 3'd1;
	localparam logic [2:0] OP_READ = 3'd2;
	localparam logic [2:0] OP_WRITE = 3'd3;
	localparam logic [2:0] OP_SQ = 3'd4;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_MISALIGN = 2'd1;
	localparam logic [1:0] STAT_MISS = 2'd2;
	localparam logic [1:0] STAT_FULL = 2'd3;

	localparam logic [1:0] SZ_1K = 2'd0;
	localparam logic [1:0] SZ_4K = 2'd1;
	localparam logic [1:0] SZ_64K = 2'd2;
	localparam logic [1:0] SZ_1M = 2'd3;

	localparam logic [5:0] AREA_MASK = 6'h3F;
	localparam logic [5:0] AREA_SQ = 6'h38;
	localparam logic [5:0] AREA_P4 = 6'h1F;

	typedef struct packed {
		logic [21:0] vpn;
		logic [18:0] ppn;
		logic [1:0]  size;
		logic [7:0]  asid;
		logic        shared;
	} entry_t;

	typedef struct packed {
		logic accept;
		logic eval;
		logic pick;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic need_scan;
		logic scan_busy;
		logic out_free;
	} sts_t;

	function automatic logic [21:0] vpn_mask(input logic [1:0] size);
		logic [21:0] m;
		begin
			unique case (size)
				SZ_1K: m = 22'h3FFFFF;
				SZ_4K: m = 22'h3FFFFC;
				SZ_64K: m = 22'h3FFFC0;
				default: m = 22'h3FFC00;
			endcase
			return m;
		end
	endfunction

	function automatic logic entry_hits(input entry_t e, input logic [31:0] va,
			input logic [7:0] asid);
		return (e.vpn == (va[31:10] & vpn_mask(e.size))) && (e.shared || e.asid == asid);
	endfunction

	function automatic logic [31:0] entry_translate(input entry_t e, input logic [31:0] va);
		logic [31:0] m;
		logic [31:0] p;
		begin
			m = {vpn_mask(e.size), 10'b0};
			p = {3'b0, e.ppn, 10'b0};
			return (p & m) | (va & ~m);
		end
	endfunction

endpackage

// ===== sv/tlbat_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module tlbat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/tlbat_ctrl.sv =====
// Controller state machine that sequences evaluation, table scan and result output.
`timescale 1ns / 1ps
module tlbat_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tlbat_pkg::sts_t   sts,
	output tlbat_pkg::cmd_t   cmd
);
	typedef enum logic [2:0] {IDLE, EVAL, SCAN, PICK, EMIT} state_t;
	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE: if (in_valid) state_q <= EVAL;
				EVAL: state_q <= sts.need_scan ? SCAN : EMIT;
				SCAN: if (!sts.scan_busy) state_q <= PICK;
				PICK: state_q <= EMIT;
				EMIT: if (sts.out_free) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	always_comb begin
		in_ready = (state_q == IDLE);
		cmd.accept = in_ready && in_valid;
		cmd.eval = (state_q == EVAL);
		cmd.pick = (state_q == PICK);
		cmd.emit = (state_q == EMIT);
	end
endmodule

// ===== sv/tlbat_dp.sv =====
// Datapath with the request registers, entry table, scan logic and result registers.
`timescale 1ns / 1ps
module tlbat_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tlbat_pkg::cmd_t        cmd,
	output tlbat_pkg::sts_t        sts,
	input  logic                   cfg_valid,
	input  logic [7:0]             cfg_data,
	input  logic [2:0]             op,
	input  logic [31:0]            vaddr,
	input  logic [1:0]             access_size,
	input  logic                   priv_mode,
	input  logic [7:0]             current_asid,
	input  logic [21:0]            entry_vpn,
	input  logic [18:0]            entry_ppn,
	input  logic [1:0]             entry_page_size,
	input  logic [7:0]             entry_asid,
	input  logic                   entry_shared,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [31:0]            paddr,
	output logic [1:0]             status
);
	logic [2:0]  op_q;
	logic [31:0] va_q;
	logic [1:0]  asz_q;
	logic        priv_q;
	logic [7:0]  asid_q;
	tlbat_pkg::entry_t new_q;

	logic [7:0] bypass_q;
	logic [tlbat_pkg::CNT_W-1:0] count_q;
	logic lh_valid_q;
	tlbat_pkg::entry_t lh_q;

	logic [tlbat_pkg::CNT_W-1:0] scan_left_q;
	logic rd_vld_s1;
	logic [3:0] found_q;
	tlbat_pkg::entry_t cand_q [4];

	logic [31:0] res_paddr_q;
	logic [1:0]  res_status_q;
	logic        out_valid_q;
	logic [31:0] paddr_q;
	logic [1:0]  status_q;

	logic [tlbat_pkg::CNT_W-1:0] scan_dec;
	logic [tlbat_pkg::ENTRY_W-1:0] rdata;
	tlbat_pkg::entry_t rd_entry;
	logic ram_we;

	logic misalign, passthru, lh_hit, full;
	logic [31:0] lh_pa;
	logic [31:0] ev_paddr;
	logic [1:0]  ev_status;
	logic need_scan;
	tlbat_pkg::entry_t pick_e;
	logic pick_hit;
	logic [31:0] pick_pa;
	logic [3:0] align_bits;

	assign scan_dec = scan_left_q - tlbat_pkg::CNT_W'(1);
	assign full = (count_q == tlbat_pkg::CNT_W'(tlbat_pkg::TABLE_DEPTH));
	assign ram_we = cmd.eval && (op_q == tlbat_pkg::OP_INSERT) && !full;
	assign rd_entry = rdata;

	tlbat_ram #(
		.WIDTH(tlbat_pkg::ENTRY_W),
		.DEPTH(tlbat_pkg::TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[tlbat_pkg::ADDR_W-1:0]),
		.wdata(new_q),
		.raddr(scan_dec[tlbat_pkg::ADDR_W-1:0]),
		.rdata(rdata)
	);

	always_comb begin
		align_bits = (4'd1 << asz_q) - 4'd1;
		misalign = (va_q[3:0] & align_bits) != 4'd0;
		passthru = ((op_q == tlbat_pkg::OP_WRITE)
				&& ((va_q[31:26] & tlbat_pkg::AREA_MASK) == tlbat_pkg::AREA_SQ))
			|| (priv_q && ((va_q[31:26] & tlbat_pkg::AREA_MASK) == tlbat_pkg::AREA_P4))
			|| bypass_q[va_q[31:29]];
		lh_hit = lh_valid_q && tlbat_pkg::entry_hits(lh_q, va_q, asid_q);
		lh_pa = tlbat_pkg::entry_translate(lh_q, va_q);
		ev_paddr = 32'd0;
		ev_status = tlbat_pkg::STAT_OK;
		need_scan = 1'b0;
		case (op_q) inside
			tlbat_pkg::OP_INSERT: begin
				if (full) ev_status = tlbat_pkg::STAT_FULL;
			end
			tlbat_pkg::OP_READ, tlbat_pkg::OP_WRITE: begin
				if (misalign) begin
					ev_status = tlbat_pkg::STAT_MISALIGN;
				end else if (passthru) begin
					ev_paddr = va_q;
				end else if (lh_hit) begin
					ev_paddr = lh_pa;
				end else begin
					need_scan = 1'b1;
				end
			end
			tlbat_pkg::OP_SQ: begin
				if (lh_hit) begin
					ev_paddr = {lh_pa[31:5], 5'b0};
				end else begin
					need_scan = 1'b1;
				end
			end
			default: ev_paddr = 32'd0;
		endcase
	end

	always_comb begin
		pick_hit = 1'b1;
		if (found_q[tlbat_pkg::SZ_4K]) begin
			pick_e = cand_q[tlbat_pkg::SZ_4K];
		end else if (found_q[tlbat_pkg::SZ_64K]) begin
			pick_e = cand_q[tlbat_pkg::SZ_64K];
		end else if (found_q[tlbat_pkg::SZ_1M]) begin
			pick_e = cand_q[tlbat_pkg::SZ_1M];
		end else begin
			pick_e = cand_q[tlbat_pkg::SZ_1K];
			pick_hit = found_q[tlbat_pkg::SZ_1K];
		end
		pick_pa = tlbat_pkg::entry_translate(pick_e, va_q);
		if (op_q == tlbat_pkg::OP_SQ) pick_pa[4:0] = 5'b0;
	end

	always_comb begin
		sts.need_scan = need_scan;
		sts.scan_busy = (scan_left_q != '0) || rd_vld_s1;
		sts.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= op;
			va_q <= vaddr;
			asz_q <= access_size;
			priv_q <= priv_mode;
			asid_q <= current_asid;
			new_q.vpn <= entry_vpn & tlbat_pkg::vpn_mask(entry_page_size);
			new_q.ppn <= entry_ppn;
			new_q.size <= entry_page_size;
			new_q.asid <= entry_asid;
			new_q.shared <= entry_shared;
		end
		if (cmd.eval) begin
			res_paddr_q <= ev_paddr;
			res_status_q <= ev_status;
		end
		if (cmd.pick) begin
			res_paddr_q <= pick_hit ? pick_pa : 32'd0;
			res_status_q <= pick_hit ? tlbat_pkg::STAT_OK : tlbat_pkg::STAT_MISS;
		end
		if (rd_vld_s1 && !found_q[rd_entry.size]
				&& tlbat_pkg::entry_hits(rd_entry, va_q, asid_q)) begin
			cand_q[rd_entry.size] <= rd_entry;
		end
		if (cmd.emit && sts.out_free) begin
			paddr_q <= res_paddr_q;
			status_q <= res_status_q;
		end
		if (ram_we || (cmd.pick && pick_hit)) begin
			lh_q <= ram_we ? new_q : pick_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= '0;
			count_q <= '0;
			lh_valid_q <= 1'b0;
			scan_left_q <= '0;
			rd_vld_s1 <= 1'b0;
			found_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) bypass_q <= cfg_data;
			if (ram_we) begin
				count_q <= count_q + tlbat_pkg::CNT_W'(1);
				lh_valid_q <= 1'b1;
			end
			if (cmd.eval && op_q == tlbat_pkg::OP_FLUSH) begin
				count_q <= '0;
				lh_valid_q <= 1'b0;
			end
			if (cmd.pick && pick_hit) lh_valid_q <= 1'b1;
			rd_vld_s1 <= (scan_left_q != '0);
			if (cmd.eval && need_scan) begin
				scan_left_q <= count_q;
				found_q <= '0;
			end else begin
				if (scan_left_q != '0) scan_left_q <= scan_dec;
				if (rd_vld_s1 && tlbat_pkg::entry_hits(rd_entry, va_q, asid_q)) begin
					found_q[rd_entry.size] <= 1'b1;
				end
			end
			if (cmd.emit && sts.out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign paddr = paddr_q;
	assign status = status_q;
endmodule

// ===== sv/tlb_address_translator_unit.sv =====
// Top level of the virtual to physical address translator.
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | op, vaddr, access_size, priv_mode, asid, entry_*
//  out     | output    | out_valid / out_ready | paddr, status
//  cfg     | input     | cfg_valid / cfg_ready | cfg_data (bypass region mask)
// A request whose answer needs no table search goes from evaluation to output, registered when the output is free.
// A table search reads one stored entry per cycle from the entry RAM, covering every
// stored entry, at most 256.
// One request is in flight at a time; a new request is taken while a result waits.
// The entry table needs no clearing after reset; cfg_ready is always high.
`timescale 1ns / 1ps
module tlb_address_translator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [31:0] vaddr,
	input  logic [1:0]  access_size,
	input  logic        priv_mode,
	input  logic [7:0]  current_asid,
	input  logic [21:0] entry_vpn,
	input  logic [18:0] entry_ppn,
	input  logic [1:0]  entry_page_size,
	input  logic [7:0]  entry_asid,
	input  logic        entry_shared,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] paddr,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	tlbat_pkg::cmd_t cmd;
	tlbat_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	tlbat_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	tlbat_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.op             (op),
		.vaddr          (vaddr),
		.access_size    (access_size),
		.priv_mode      (priv_mode),
		.current_asid   (current_asid),
		.entry_vpn      (entry_vpn),
		.entry_ppn      (entry_ppn),
		.entry_page_size(entry_page_size),
		.entry_asid     (entry_asid),
		.entry_shared   (entry_shared),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.paddr          (paddr),
		.status         (status)
	);
endmodule

// ===== sv/tlbat_chk.sv =====
// Port-level checker for the address translator, bound to the top level.
`timescale 1ns / 1ps
`include "tlb_address_translator_unit_defines.svh"
module tlbat_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] paddr,
	input logic [1:0]  status,
	input logic        cfg_ready
);
	`TLBAT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`TLBAT_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(paddr) && $stable(status))
	`TLBAT_ASSERT(a_err_zero, !out_valid || status == tlbat_pkg::STAT_OK || paddr == 32'd0)
	`TLBAT_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
	`TLBAT_ASSERT(a_cfg_ready, cfg_ready)
endmodule

bind tlb_address_translator_unit tlbat_chk u_tlbat_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.paddr    (paddr),
	.status   (status),
	.cfg_ready(cfg_ready)
);

// ===== dv/tb_tlb_address_translator_unit.sv =====
// Testbench for the address translator: directed table, random traffic, self-checking predictor.
`timescale 1ns / 1ps
module tb_tlb_address_translator_unit;

	typedef struct packed {
		logic [31:0] paddr;
		logic [1:0]  status;
	} answer_t;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] va;
		logic [1:0]  asz;
		logic        priv;
		logic [7:0]  asid;
		logic [21:0] vpn;
		logic [18:0] ppn;
		logic [1:0]  psz;
		logic [7:0]  easid;
		logic        shared;
		logic        fixed;
		logic [31:0] exp_paddr;
		logic [1:0]  exp_status;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  op;
	logic [31:0] vaddr;
	logic [1:0]  access_size;
	logic        priv_mode;
	logic [7:0]  current_asid;
	logic [21:0] entry_vpn;
	logic [18:0] entry_ppn;
	logic [1:0]  entry_page_size;
	logic [7:0]  entry_asid;
	logic        entry_shared;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] paddr;
	logic [1:0]  status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	tlbat_pkg::entry_t mdl_table [tlbat_pkg::TABLE_DEPTH];
	int          mdl_count;
	logic        mdl_last_valid;
	tlbat_pkg::entry_t mdl_last;
	logic [7:0]  mdl_bypass;
	answer_t     pending_answers[$];
	row_t        directed [$];
	int          errors;
	int          send_idle_pct;
	int          recv_stall_pct;

	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_MID = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	tlb_address_translator_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .vaddr(vaddr), .access_size(access_size), .priv_mode(priv_mode),
		.current_asid(current_asid), .entry_vpn(entry_vpn), .entry_ppn(entry_ppn),
		.entry_page_size(entry_page_size), .entry_asid(entry_asid),
		.entry_shared(entry_shared),
		.out_valid(out_valid), .out_ready(out_ready), .paddr(paddr), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic [31:0] page_mask(input logic [1:0] sz);
		case (sz)
			tlbat_pkg::SZ_1K: return 32'hFFFFFC00;
			tlbat_pkg::SZ_4K: return 32'hFFFFF000;
			tlbat_pkg::SZ_64K: return 32'hFFFF0000;
			default: return 32'hFFF00000;
		endcase
	endfunction

	function automatic logic page_match(input tlbat_pkg::entry_t e, input logic [31:0] va,
			input logic [7:0] asid);
		return ({e.vpn, 10'b0} == (va & page_mask(e.size))) && (e.shared || e.asid == asid);
	endfunction

	function automatic logic [31:0] page_xlate(input tlbat_pkg::entry_t e,
			input logic [31:0] va);
		logic [31:0] m;
		m = page_mask(e.size);
		return ({3'b0, e.ppn, 10'b0} & m) | (va & ~m);
	endfunction

	task automatic search_pages(input logic [31:0] va, input logic [7:0] asid,
			output logic hit, output logic [31:0] pa);
		logic [1:0] order [4];
		order = '{tlbat_pkg::SZ_4K, tlbat_pkg::SZ_64K, tlbat_pkg::SZ_1M, tlbat_pkg::SZ_1K};
		hit = 1'b0;
		pa = '0;
		if (mdl_last_valid && page_match(mdl_last, va, asid)) begin
			hit = 1'b1;
			pa = page_xlate(mdl_last, va);
			return;
		end
		foreach (order[k]) begin
			for (int i = mdl_count - 1; i >= 0; i--) begin
				if (mdl_table[i].size == order[k] && page_match(mdl_table[i], va, asid)) begin
					hit = 1'b1;
					pa = page_xlate(mdl_table[i], va);
					mdl_last = mdl_table[i];
					mdl_last_valid = 1'b1;
					return;
				end
			end
		end
	endtask

	task automatic predict_translation(input row_t r, output answer_t a);
		tlbat_pkg::entry_t e;
		logic hit;
		logic [31:0] pa;
		a = '0;
		case (r.op) inside
			tlbat_pkg::OP_INSERT: begin
				if (mdl_count >= tlbat_pkg::TABLE_DEPTH) begin
					a.status = tlbat_pkg::STAT_FULL;
				end else begin
					e.size = r.psz;
					e.vpn = r.vpn & 22'(page_mask(r.psz) >> 10);
					e.ppn = r.ppn;
					e.asid = r.easid;
					e.shared = r.shared;
					mdl_table[mdl_count] = e;
					mdl_count++;
					mdl_last = e;
					mdl_last_valid = 1'b1;
				end
			end
			tlbat_pkg::OP_FLUSH: begin
				mdl_count = 0;
				mdl_last_valid = 1'b0;
			end
			tlbat_pkg::OP_READ, tlbat_pkg::OP_WRITE: begin
				if ((r.va & ((32'd1 << r.asz) - 32'd1)) != 32'd0) begin
					a.status = tlbat_pkg::STAT_MISALIGN;
				end else if (r.op == tlbat_pkg::OP_WRITE
						&& r.va[31:26] == tlbat_pkg::AREA_SQ) begin
					a.paddr = r.va;
				end else if (r.priv && r.va[31:26] == tlbat_pkg::AREA_P4) begin
					a.paddr = r.va;
				end else if (mdl_bypass[r.va[31:29]]) begin
					a.paddr = r.va;
				end else begin
					search_pages(r.va, r.asid, hit, pa);
					if (hit) a.paddr = pa;
					else a.status = tlbat_pkg::STAT_MISS;
				end
			end
			tlbat_pkg::OP_SQ: begin
				search_pages(r.va, r.asid, hit, pa);
				if (hit) a.paddr = pa & ~32'd31;
				else a.status = tlbat_pkg::STAT_MISS;
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic add_row(input row_t r);
		directed = {directed, r};
	endtask

	// Called at a falling edge; returns at a falling edge with in_valid still high.
	task automatic send_request(input row_t r);
		answer_t a;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		op = r.op;
		vaddr = r.va;
		access_size = r.asz;
		priv_mode = r.priv;
		current_asid = r.asid;
		entry_vpn = r.vpn;
		entry_ppn = r.ppn;
		entry_page_size = r.psz;
		entry_asid = r.easid;
		entry_shared = r.shared;
		in_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (in_ready) break;
		end
		predict_translation(r, a);
		if (r.fixed) begin
			a.paddr = r.exp_paddr;
			a.status = r.exp_status;
		end
		pending_answers = {pending_answers, a};
		@(negedge clk);
	endtask

	task automatic write_bypass(input logic [7:0] value);
		in_valid = 1'b0;
		while (pending_answers.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_data = value;
		cfg_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		mdl_bypass = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic row_t plain_row(input logic [2:0] o, input logic [31:0] va,
			input logic [1:0] asz, input logic priv, input logic [7:0] asid);
		row_t r;
		r = '{default: '0};
		r.op = o;
		r.va = va;
		r.asz = asz;
		r.priv = priv;
		r.asid = asid;
		return r;
	endfunction

	function automatic row_t insert_row(input logic [21:0] vpn, input logic [18:0] ppn,
			input logic [1:0] psz, input logic [7:0] easid, input logic shared);
		row_t r;
		r = '{default: '0};
		r.op = tlbat_pkg::OP_INSERT;
		r.vpn = vpn;
		r.ppn = ppn;
		r.psz = psz;
		r.easid = easid;
		r.shared = shared;
		return r;
	endfunction

	function automatic row_t known(input row_t r, input logic [31:0] pa, input logic [1:0] st);
		r.fixed = 1'b1;
		r.exp_paddr = pa;
		r.exp_status = st;
		return r;
	endfunction

	function automatic row_t random_row(input int insert_pct);
		row_t r;
		tlbat_pkg::entry_t e;
		int pick;
		logic [31:0] m;
		r = '{default: '0};
		r.va = $urandom;
		r.asz = 2'($urandom_range(3));
		r.priv = 1'($urandom_range(1));
		r.asid = ($urandom_range(1)) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
		r.vpn = 22'($urandom);
		r.ppn = 19'($urandom);
		r.psz = 2'($urandom_range(3));
		r.easid = ($urandom_range(1)) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
		r.shared = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < insert_pct) begin
			r.op = tlbat_pkg::OP_INSERT;
			return r;
		end
		pick = $urandom_range(99);
		if (pick < 3) r.op = tlbat_pkg::OP_FLUSH;
		else if (pick < 5) r.op = 3'(5 + $urandom_range(2));
		else if (pick < 45) r.op = tlbat_pkg::OP_READ;
		else if (pick < 75) r.op = tlbat_pkg::OP_WRITE;
		else r.op = tlbat_pkg::OP_SQ;
		if (mdl_count > 0 && $urandom_range(99) < 75) begin
			e = mdl_table[$urandom_range(mdl_count - 1)];
			m = page_mask(e.size);
			r.va = ({e.vpn, 10'b0} & m) | (r.va & ~m);
			if (!e.shared) r.asid = e.asid;
		end else if ($urandom_range(9) == 0) begin
			r.va[31:26] = ($urandom_range(1)) ? tlbat_pkg::AREA_SQ : tlbat_pkg::AREA_P4;
		end
		if ($urandom_range(99) < 85) r.va = r.va & ~((32'd1 << r.asz) - 32'd1);
		return r;
	endfunction

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected result paddr", paddr, 32'd0);
			end else begin
				want = pending_answers.pop_front();
				if (paddr !== want.paddr) report_mismatch("paddr", paddr, want.paddr);
				if (status !== want.status) report_mismatch("status", 32'(status), 32'(want.status));
			end
		end
	end

	initial begin
		#20ms;
		$display("tb_tlb_address_translator_unit: FAIL");
		$finish;
	end

	initial begin
		logic [7:0] bypass_list [6];
		int modes_in [4];
		int modes_out [4];
		int waited;
		errors = 0;
		mdl_count = 0;
		mdl_last_valid = 1'b0;
		mdl_last = '0;
		mdl_bypass = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = tlbat_pkg::OP_FLUSH;
		vaddr = '0;
		access_size = '0;
		priv_mode = 1'b0;
		current_asid = '0;
		entry_vpn = '0;
		entry_ppn = '0;
		entry_page_size = '0;
		entry_asid = '0;
		entry_shared = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		add_row(known(plain_row(tlbat_pkg::OP_READ, 32'h0, 2'd0, 1'b0, 8'h00), 32'h0,
			tlbat_pkg::STAT_MISS));
		add_row(known(plain_row(tlbat_pkg::OP_SQ, 32'hFFFFFFFF, 2'd3, 1'b1, 8'hFF), 32'h0,
			tlbat_pkg::STAT_MISS));
		add_row(known(plain_row(tlbat_pkg::OP_READ, 32'h1, 2'd1, 1'b0, 8'h00), 32'h0,
			tlbat_pkg::STAT_MISALIGN));
		add_row(known(plain_row(tlbat_pkg::OP_WRITE, 32'hFFFFFFFF, 2'd3, 1'b1, 8'hFF), 32'h0,
			tlbat_pkg::STAT_MISALIGN));
		add_row(known(plain_row(tlbat_pkg::OP_WRITE, 32'hE0000010, 2'd2, 1'b0, 8'h00),
			32'hE0000010, tlbat_pkg::STAT_OK));
		add_row(known(plain_row(tlbat_pkg::OP_READ, 32'hE0000010, 2'd2, 1'b0, 8'h00), 32'h0,
			tlbat_pkg::STAT_MISS));
		add_row(known(plain_row(tlbat_pkg::OP_READ, 32'h7C000000, 2'd3, 1'b1, 8'h00),
			32'h7C000000, tlbat_pkg::STAT_OK));
		add_row(known(plain_row(tlbat_pkg::OP_READ, 32'h7C000000, 2'd3, 1'b0, 8'h00), 32'h0,
			tlbat_pkg::STAT_MISS));
		add_row(known(insert_row(22'h3FFFFF, 19'h7FFFF, tlbat_pkg::SZ_1M, 8'hFF, 1'b0), 32'h0,
			tlbat_pkg::STAT_OK));
		add_row(plain_row(tlbat_pkg::OP_READ, 32'hFFFFFFF8, 2'd3, 1'b0, 8'hFF));
		add_row(plain_row(tlbat_pkg::OP_READ, 32'hFFFFFFF8, 2'd3, 1'b0, 8'h00));
		add_row(insert_row(22'h0, 19'h0, tlbat_pkg::SZ_1K, 8'h00, 1'b1));
		add_row(plain_row(tlbat_pkg::OP_SQ, 32'h000003FF, 2'd0, 1'b0, 8'h05));
		add_row(insert_row(22'h000123, 19'h00456, tlbat_pkg::SZ_4K, 8'h01, 1'b0));
		add_row(insert_row(22'h000120, 19'h01230, tlbat_pkg::SZ_64K, 8'h01, 1'b0));
		add_row(insert_row(22'h000000, 19'h7FFFF, tlbat_pkg::SZ_1K, 8'h02, 1'b1));
		add_row(plain_row(tlbat_pkg::OP_READ, 32'h00048C04, 2'd2, 1'b0, 8'h01));
		add_row(plain_row(tlbat_pkg::OP_WRITE, 32'h00048FFE, 2'd1, 1'b0, 8'h01));
		add_row(plain_row(tlbat_pkg::OP_SQ, 32'h0004BFFF, 2'd0, 1'b0, 8'h01));
		add_row(known(plain_row(OP_UNUSED_LO, 32'hFFFFFFFF, 2'd3, 1'b1, 8'hFF), 32'h0,
			tlbat_pkg::STAT_OK));
		add_row(known(plain_row(OP_UNUSED_MID, 32'h0, 2'd0, 1'b0, 8'h0), 32'h0,
			tlbat_pkg::STAT_OK));
		add_row(known(plain_row(OP_UNUSED_HI, 32'h00048C04, 2'd2, 1'b0, 8'h1), 32'h0,
			tlbat_pkg::STAT_OK));
		add_row(known(plain_row(tlbat_pkg::OP_FLUSH, 32'h0, 2'd0, 1'b0, 8'h0), 32'h0,
			tlbat_pkg::STAT_OK));
		add_row(known(plain_row(tlbat_pkg::OP_READ, 32'h00048C04, 2'd2, 1'b0, 8'h01), 32'h0,
			tlbat_pkg::STAT_MISS));
		foreach (directed[i]) send_request(directed[i]);

		// Fill the table to the brim, probe a full table, then empty it.
		write_bypass(8'h00);
		for (int i = 0; i < tlbat_pkg::TABLE_DEPTH + 3; i++) send_request(random_row(100));
		for (int i = 0; i < 6; i++) send_request(random_row(0));
		send_request(plain_row(tlbat_pkg::OP_FLUSH, 32'h0, 2'd0, 1'b0, 8'h0));

		bypass_list = '{8'hFF, 8'h00, 8'(1 << 7), 8'h81, 8'($urandom), 8'h00};
		modes_in = '{0, 65, 0, 12};
		modes_out = '{0, 0, 65, 12};
		for (int p = 0; p < 6; p++) begin
			write_bypass(bypass_list[p]);
			send_idle_pct = modes_in[p % 4];
			recv_stall_pct = modes_out[p % 4];
			for (int i = 0; i < 55; i++) begin
				if (mdl_count > 24 && $urandom_range(9) == 0)
					send_request(plain_row(tlbat_pkg::OP_FLUSH, 32'h0, 2'd0, 1'b0, 8'h0));
				else
					send_request(random_row(25));
			end
		end
		in_valid = 1'b0;

		waited = 0;
		while (pending_answers.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (300) @(posedge clk);
		if (errors == 0 && pending_answers.size() == 0) begin
			$display("tb_tlb_address_translator_unit: PASS");
		end else begin
			$display("tb_tlb_address_translator_unit: FAIL");
		end
		$finish;
	end

endmodule
